>>> sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions for the 3x3 median filter
// Widths, register indexes, reset values and the window type that the core
// hands to the median selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int MF3_MAX_WIDTH   = 1024;  // default line store depth
  localparam int MAX_HEIGHT      = 4096;
  localparam int PIX_W           = 8;
  localparam int ROW_W           = 12;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int RST_WIDTH       = 512;
  localparam int RST_HEIGHT      = 512;

  localparam int WIN_DIM = 3;
  localparam int WIN_N   = WIN_DIM * WIN_DIM;
  localparam int RANK_W  = $clog2(WIN_N + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Window positions are numbered row * 3 + column. Positions whose valid bit
  // is clear carry zero and take no part in the median.
  typedef struct packed {
    logic [WIN_N-1:0]            valid;
    logic [WIN_N-1:0][PIX_W-1:0] pix;
  } median_in_t;

endpackage

`default_nettype wire

>>> sv/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median: median of the valid positions of a 3x3 window
// Each valid value is ranked against the others (ties broken by position);
// the value whose rank equals half the valid count is the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mf3_median (
  input  mf3_pkg::median_in_t       med_in,
  output logic [mf3_pkg::PIX_W-1:0] median
);

  import mf3_pkg::*;

  logic [RANK_W-1:0] n_valid;
  logic [RANK_W-1:0] target;
  logic [RANK_W-1:0] rank [WIN_N];
  logic [WIN_N-1:0]  sel;

  always_comb begin
    n_valid = RANK_W'($countones(med_in.valid));
    target  = n_valid >> 1;
    for (int i = 0; i < WIN_N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        if (j != i && med_in.valid[j] &&
            (med_in.pix[j] < med_in.pix[i] ||
             (med_in.pix[j] == med_in.pix[i] && j < i))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
      sel[i] = med_in.valid[i] && (rank[i] == target);
    end
  end

  // Ranks form a permutation of the valid values, so exactly one is selected.
  always_comb begin
    median = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (sel[i]) begin
        median = median | med_in.pix[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/median_filter_3x3_core.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_core: streaming 3x3 median filter for 8-bit grey pixels
// Salt-and-pepper noise removal on a raster pixel stream, with two line stores.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a pixel (in_tuser = 0) or a flush tick (in_tuser = 1) in
//   in_tdata. Pixels of a frame come in raster order; the output for row r-1
//   is produced while row r streams in. After the last pixel of a frame, one
//   flush beat per column drains the last row; out_tlast marks the final
//   pixel of the frame. Window positions outside the image are left out and
//   the median is the upper median of the valid values.
//   The configuration channel writes image_width (index 0) and image_height
//   (index 1); a write restarts the frame and drops pending flush outputs.
//   An accepted beat is registered in the working stage and then in the output
//   register. Throughput: one beat per cycle while the output does not stall,
//   apart from the last pixel of a row. In every row but the first of a
//   frame, that pixel gives two results (only one when the width is one) and
//   holds the input until its results are loaded. A flush with nothing left
//   to drain gives no result.
//   When the receiver stalls, the output register holds its beat and the
//   working stage behind it fills, after which in_tready drops.
//   Reset clears counters and the pipeline and restores width and height to
//   512. The line stores are not cleared; never-written entries are only read
//   at positions outside the image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_core #(
  parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mf3_pkg::PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic                           in_tuser,   // [0] mode (1 = flush)
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mf3_pkg::PIX_W-1:0]      out_tdata,  // [7:0] filtered_pixel
  output logic                           out_tlast,  // frame_end
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mf3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int W_M1_RST_I = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH - 1 : RST_WIDTH - 1;
  localparam logic [AW-1:0]    W_M1_RST = AW'(W_M1_RST_I);
  localparam logic [ROW_W-1:0] H_M1_RST = ROW_W'(RST_HEIGHT - 1);

  // Effective geometry, held as width-1 and height-1.
  logic [AW-1:0]    w_m1_r;
  logic [ROW_W-1:0] h_m1_r;

  // Position of the next pixel and the drain position of the last row.
  logic [AW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic             fl_active_r;
  logic [AW-1:0]    fl_col_r;

  // Working stage: the accepted beat plus the line store data for it.
  logic             s1_valid_r;
  logic             s1_done_a_r;
  logic             s1_flush_r;
  logic             s1_has_a_r;
  logic             s1_has_b_r;
  logic             s1_top_ok_r;
  logic             s1_col_ge1_r;
  logic             s1_col_ge2_r;
  logic             s1_right_ok_r;
  logic             s1_last_r;
  logic [AW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [PIX_W-1:0] rda_up_r;
  logic [PIX_W-1:0] rda_lo_r;
  logic [PIX_W-1:0] rdb_up_r;
  logic [PIX_W-1:0] rdb_lo_r;

  // Two left columns of the window, rows top to bottom.
  logic [WIN_DIM-1:0][PIX_W-1:0] win0_r;
  logic [WIN_DIM-1:0][PIX_W-1:0] win1_r;

  // Line stores: upper holds the row two above, lower the row just above.
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];

  logic             out_valid_r;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  logic             in_acc;
  logic             cfg_acc;
  logic             col_last;
  logic             row_last;
  logic             fl_last;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic             wr_en;
  logic             fwd_a;
  logic             fwd_b;
  logic             emit_a;
  logic             s1_has_res;
  logic             slot_free;
  logic             s1_adv;
  logic             out_load;

  logic [CFG_WIDTH_BITS-1:0]  cfg_wv;
  logic [CFG_HEIGHT_BITS-1:0] cfg_hv;
  logic [AW-1:0]              w_m1_cfg;
  logic [ROW_W-1:0]           h_m1_cfg;

  logic [WIN_DIM-1:0][WIN_DIM-1:0][PIX_W-1:0] win_val;  // [column][row]
  logic [WIN_DIM-1:0] row_ok;
  logic [WIN_DIM-1:0] col_ok;
  median_in_t         med_in;
  logic [PIX_W-1:0]   median;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign col_last = (col_r == w_m1_r);
  assign row_last = (row_r == h_m1_r);
  assign fl_last  = (fl_col_r == w_m1_r);

  // A flush reads its own column on port A and the one to its right on
  // port B; a pixel reads its column on port A.
  assign addr_a = in_tuser ? fl_col_r : col_r;
  assign addr_b = fl_last ? fl_col_r : fl_col_r + 1'b1;

  // Output sequencing. A pixel may owe a centered result (A) and, at the end
  // of a row, the result for the rightmost column (B); a flush owes at most A.
  assign emit_a     = s1_has_a_r && !s1_done_a_r;
  assign s1_has_res = emit_a || s1_has_b_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign s1_adv     = s1_valid_r &&
                      (!s1_has_res || (slot_free && !(emit_a && s1_has_b_r)));
  assign out_load   = s1_valid_r && s1_has_res && slot_free;
  assign in_tready  = !s1_valid_r || s1_adv;

  // The store update of a pixel lands as it leaves the working stage; a read
  // at the same edge and address takes the new data directly.
  assign wr_en = s1_adv && !s1_flush_r;
  assign fwd_a = wr_en && (s1_col_r == addr_a);
  assign fwd_b = wr_en && (s1_col_r == addr_b);

  // Configuration values mapped into range.
  assign cfg_wv = cfg_data[CFG_WIDTH_BITS-1:0];
  assign cfg_hv = cfg_data[CFG_HEIGHT_BITS-1:0];

  always_comb begin
    if (cfg_wv == '0) begin
      w_m1_cfg = '0;
    end else if (int'(cfg_wv) > MAX_WIDTH) begin
      w_m1_cfg = AW'(MAX_WIDTH - 1);
    end else begin
      w_m1_cfg = AW'(cfg_wv - 1'b1);
    end
    if (cfg_hv == '0) begin
      h_m1_cfg = '0;
    end else if (int'(cfg_hv) > MAX_HEIGHT) begin
      h_m1_cfg = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1_cfg = ROW_W'(cfg_hv - 1'b1);
    end
  end

  // Window assembly and valid masks for the result now owed.
  always_comb begin
    if (s1_flush_r) begin
      // Rows are the last two rows of the frame; the bottom row is unused.
      win_val[0] = win1_r;
      win_val[1] = {PIX_W'(0), rda_lo_r, rda_up_r};
      win_val[2] = {PIX_W'(0), rdb_lo_r, rdb_up_r};
      row_ok     = {1'b0, 1'b1, s1_top_ok_r};
      col_ok     = {s1_right_ok_r, 1'b1, s1_col_ge1_r};
    end else begin
      win_val[0] = win0_r;
      win_val[1] = win1_r;
      win_val[2] = {s1_px_r, rda_lo_r, rda_up_r};
      row_ok     = {1'b1, 1'b1, s1_top_ok_r};
      if (emit_a) begin
        col_ok = {1'b1, 1'b1, s1_col_ge2_r};
      end else begin
        // Rightmost column of the row: its right neighbor is outside.
        col_ok = {1'b1, s1_col_ge1_r, 1'b0};
      end
    end
    for (int r = 0; r < WIN_DIM; r++) begin
      for (int c = 0; c < WIN_DIM; c++) begin
        med_in.valid[r * WIN_DIM + c] = row_ok[r] && col_ok[c];
        med_in.pix[r * WIN_DIM + c]   = (row_ok[r] && col_ok[c]) ? win_val[c][r] : '0;
      end
    end
  end

  mf3_median u_median (
    .med_in (med_in),
    .median (median)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r      <= W_M1_RST;
      h_m1_r      <= H_M1_RST;
      col_r       <= '0;
      row_r       <= '0;
      fl_active_r <= 1'b0;
      fl_col_r    <= '0;
      s1_valid_r  <= 1'b0;
      s1_done_a_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (in_acc || s1_adv) begin
        s1_done_a_r <= 1'b0;
      end else if (out_load) begin
        s1_done_a_r <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_acc) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            w_m1_r      <= w_m1_cfg;
            col_r       <= '0;
            row_r       <= '0;
            fl_active_r <= 1'b0;
          end
          CFG_IMAGE_HEIGHT: begin
            h_m1_r      <= h_m1_cfg;
            col_r       <= '0;
            row_r       <= '0;
            fl_active_r <= 1'b0;
          end
          default: begin
          end
        endcase
      end else if (in_acc && !in_tuser) begin
        // A pixel drops whatever of the last row was still to drain; the
        // last pixel of a frame opens a new drain.
        if (col_last) begin
          col_r <= '0;
          if (row_last) begin
            row_r       <= '0;
            fl_active_r <= 1'b1;
            fl_col_r    <= '0;
          end else begin
            row_r       <= row_r + 1'b1;
            fl_active_r <= 1'b0;
          end
        end else begin
          col_r       <= col_r + 1'b1;
          fl_active_r <= 1'b0;
        end
      end else if (in_acc && fl_active_r) begin
        if (fl_last) begin
          fl_active_r <= 1'b0;
        end else begin
          fl_col_r <= fl_col_r + 1'b1;
        end
      end
    end
  end

  // Working stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_flush_r <= in_tuser;
      s1_px_r    <= in_tdata;
      s1_col_r   <= col_r;
      if (in_tuser) begin
        s1_has_a_r    <= fl_active_r;
        s1_has_b_r    <= 1'b0;
        s1_top_ok_r   <= (h_m1_r != '0);
        s1_col_ge1_r  <= (fl_col_r != '0);
        s1_col_ge2_r  <= 1'b0;
        s1_right_ok_r <= !fl_last;
        s1_last_r     <= fl_last;
      end else begin
        s1_has_a_r    <= (row_r != '0) && (col_r != '0);
        s1_has_b_r    <= (row_r != '0) && col_last;
        s1_top_ok_r   <= (row_r >= ROW_W'(2));
        s1_col_ge1_r  <= (col_r != '0);
        s1_col_ge2_r  <= (col_r >= AW'(2));
        s1_right_ok_r <= 1'b0;
        s1_last_r     <= 1'b0;
      end
    end

    if (s1_adv) begin
      if (s1_flush_r) begin
        // Only a draining flush moves the window; an idle flush leaves the
        // frame in progress untouched.
        if (s1_has_a_r) begin
          win1_r <= {PIX_W'(0), rda_lo_r, rda_up_r};
        end
      end else begin
        win0_r <= win1_r;
        win1_r <= {s1_px_r, rda_lo_r, rda_up_r};
      end
    end

    if (out_load) begin
      out_data_r <= median;
      out_last_r <= s1_flush_r && s1_last_r;
    end
  end

  // Line stores: one write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[s1_col_r] <= rda_lo_r;
      lower_mem[s1_col_r] <= s1_px_r;
    end
    if (in_acc) begin
      rda_up_r <= fwd_a ? rda_lo_r : upper_mem[addr_a];
      rda_lo_r <= fwd_a ? s1_px_r  : lower_mem[addr_a];
      rdb_up_r <= fwd_b ? rda_lo_r : upper_mem[addr_b];
      rdb_lo_r <= fwd_b ? s1_px_r  : lower_mem[addr_b];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> sv/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker: port-level assertions for the 3x3 median filter core
// Watches the stream ports over time and is attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mf3_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [mf3_pkg::PIX_W-1:0] out_tdata,
  input logic                      out_tlast
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Reset empties the pipeline: no result and the input open.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // A frame-end result is loaded only as its flush beat leaves the working
  // stage, which frees the input in that same cycle.
  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && ($past(!out_tvalid) || $past(out_tready))
    |-> $past(in_tready))
    else $error("frame-end result loaded while input was held");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
